FILE: hdl/ssc_pkg.sv
// ssc_pkg: shared constants, codes and types of the sbox stream cipher
// depends on nothing; used by the interfaces, controller, datapath and top level
`default_nettype none

package ssc_pkg;

   // fixed widths of bytes, words and the s-box
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int SBOX_DEPTH  = 256;
   localparam int SBOX_AW     = 8;

   // key and nonce register file layout
   localparam int KEY_REG_BYTES   = 32;
   localparam int NONCE_REG_BYTES = 16;
   localparam int KEY_SEL_W       = 5;
   localparam int NONCE_SEL_W     = 4;
   localparam int KEYLEN_W        = 6;
   localparam int NONCELEN_W      = 5;
   localparam logic [KEYLEN_W-1:0]   KEYLEN_RESET   = 6'd32;
   localparam logic [NONCELEN_W-1:0] NONCELEN_RESET = 5'd16;

   // mixing loop
   localparam int MIX_ROUNDS = 768;
   localparam int CNT_W      = 10;

   // defaults for the top level parameters
   localparam int DEF_MAX_KEY_BYTES   = 32;
   localparam int DEF_MAX_NONCE_BYTES = 16;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_LOW     = 3'd0,
      CSR_KEY_SECOND  = 3'd1,
      CSR_KEY_THIRD   = 3'd2,
      CSR_KEY_HIGH    = 3'd3,
      CSR_NONCE_LOW   = 3'd4,
      CSR_NONCE_HIGH  = 3'd5,
      CSR_KEY_LENGTH  = 3'd6,
      CSR_NONCE_LENGTH = 3'd7
   } csr_idx_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_KEY,
      ST_MIX,
      ST_SW_A,
      ST_SW_B,
      ST_SW_C,
      ST_SW_D,
      ST_NONCE,
      ST_DT_A,
      ST_DT_B,
      ST_DT_C,
      ST_DT_D
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_KEY,
      OP_MIX,
      OP_NONCE,
      OP_SW_A,
      OP_SW_B,
      OP_SW_C,
      OP_SW_D,
      OP_DT_A,
      OP_DT_B,
      OP_DT_C,
      OP_DT_D
   } op_type;

   // controller to datapath
   typedef struct packed {
      op_type op;
      logic   capture;
   } ssc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic loop_last;
      logic nonce_empty;
   } ssc_stat_type;

endpackage

`default_nettype wire

FILE: hdl/ssc_channels.sv
// ssc channel interfaces: input word, result word and configuration write
// depends on ssc_pkg for field widths
`default_nettype none

interface ssc_req_if
   import ssc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface ssc_rsp_if
   import ssc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

interface ssc_csr_if
   import ssc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/sbox_stream_cipher.sv
// sbox_stream_cipher: top level, joins ssc_ctrl and ssc_dpath to the channels
// depends on ssc_pkg, ssc_channels, ssc_ctrl and ssc_dpath
//
// Usage
//   req_chan carries one word: a data byte and a restart flag. rsp_chan returns
//   one word per input: the byte XOR the keystream byte. csr_chan writes the
//   key, nonce and length registers; it is always ready and must only be used
//   while no word is in flight.
//   A key schedule runs before the first word after reset and before every word
//   with restart set: it clears the state, folds in the key bytes, runs a mixing
//   loop and an s-box swap, folds in the nonce bytes if there are any, then runs
//   a second mixing loop and swap, one key-state update per cycle in each loop.
//   Without a schedule the first keystream step overlaps the accepting cycle; the
//   steps are key-state read, key-state update with s-box read, and two s-box writes
//   through the single s-box port, and no new word is taken until they are done.
//   req_chan.ready is high only while the block is between words.
//   The result sits in an output register; if the receiver stalls, the block
//   still accepts the next word and holds its final step until the register
//   is taken.
//   Synchronous reset returns the registers to their defaults, marks the
//   schedule as not run and drops any pending result.
`default_nettype none

module sbox_stream_cipher
   import ssc_pkg::*;
   #(
   parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
   parameter int MAX_NONCE_BYTES = DEF_MAX_NONCE_BYTES
   )
   (
   input wire logic  clock,
   input wire logic  reset,
   ssc_req_if.sink   req_chan,
   ssc_rsp_if.source rsp_chan,
   ssc_csr_if.sink   csr_chan
   );

   ssc_cmd_type  cmd;
   ssc_stat_type stat;

   // sequencer
   ssc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_restart (req_chan.restart),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // datapath
   ssc_dpath #(
      .MAX_KEY_BYTES   (MAX_KEY_BYTES),
      .MAX_NONCE_BYTES (MAX_NONCE_BYTES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data_byte (req_chan.data_byte),
      .csr_valid     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .rsp_out_byte  (rsp_chan.out_byte)
   );

   // register writes are always accepted
   assign csr_chan.ready = 1'b1;

endmodule

`default_nettype wire

FILE: hdl/ssc_ctrl.sv
// ssc_ctrl: sequencer for key schedule and per-word keystream steps
// depends on ssc_pkg; drives ssc_dpath through ssc_cmd_type
`default_nettype none

module ssc_ctrl
   import ssc_pkg::*;
   (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_restart,
   output      logic         req_ready,
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire ssc_stat_type stat,
   output      ssc_cmd_type  cmd
   );

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      sready_ff, sready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_load;

   // state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         sready_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         sready_ff    <= sready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      sready_in   = sready_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      cmd.op      = OP_NOP;
      cmd.capture = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_restart || !sready_ff) begin
                  state_in = ST_CLEAR;
               end else begin
                  // first keystream step overlaps the accept cycle
                  cmd.op   = OP_DT_A;
                  state_in = ST_DT_B;
               end
            end
         end
         ST_CLEAR: begin
            cmd.op   = OP_CLEAR;
            pass_in  = 1'b0;
            state_in = ST_KEY;
         end
         ST_KEY: begin
            cmd.op = OP_KEY;
            if (stat.loop_last) state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.op = OP_MIX;
            if (stat.loop_last) state_in = ST_SW_A;
         end
         ST_SW_A: begin
            cmd.op   = OP_SW_A;
            state_in = ST_SW_B;
         end
         ST_SW_B: begin
            cmd.op   = OP_SW_B;
            state_in = ST_SW_C;
         end
         ST_SW_C: begin
            cmd.op   = OP_SW_C;
            state_in = ST_SW_D;
         end
         ST_SW_D: begin
            cmd.op = OP_SW_D;
            if (!pass_ff) begin
               pass_in  = 1'b1;
               state_in = stat.nonce_empty ? ST_MIX : ST_NONCE;
            end else begin
               sready_in = 1'b1;
               state_in  = ST_DT_A;
            end
         end
         ST_NONCE: begin
            cmd.op = OP_NONCE;
            if (stat.loop_last) state_in = ST_MIX;
         end
         ST_DT_A: begin
            cmd.op   = OP_DT_A;
            state_in = ST_DT_B;
         end
         ST_DT_B: begin
            cmd.op   = OP_DT_B;
            state_in = ST_DT_C;
         end
         ST_DT_C: begin
            cmd.op   = OP_DT_C;
            state_in = ST_DT_D;
         end
         ST_DT_D: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_DT_D;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/ssc_dpath.sv
// ssc_dpath: config registers, key-state array, s-box memory and mixing adders
// depends on ssc_pkg; commanded by ssc_ctrl
`default_nettype none

module ssc_dpath
   import ssc_pkg::*;
   #(
   parameter int MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
   parameter int MAX_NONCE_BYTES = DEF_MAX_NONCE_BYTES
   )
   (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ssc_cmd_type          cmd,
   output      ssc_stat_type         stat,
   input  wire logic [BYTE_W-1:0]    req_data_byte,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data,
   output      logic [BYTE_W-1:0]    rsp_out_byte
   );

   localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int KLEN_W = KIDX_W + 1;
   localparam int NLEN_W = (MAX_NONCE_BYTES > 0) ? $clog2(MAX_NONCE_BYTES + 1) : 1;

   // configuration registers
   logic [WORD_W-1:0]     key_low_ff, key_second_ff, key_third_ff, key_high_ff;
   logic [WORD_W-1:0]     nonce_low_ff, nonce_high_ff;
   logic [KEYLEN_W-1:0]   key_len_ff;
   logic [NONCELEN_W-1:0] nonce_len_ff;

   // schedule and stream state
   logic [KLEN_W-1:0]  klen_ff;
   logic [NLEN_W-1:0]  nlen_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [KIDX_W-1:0]  pos_ff;
   logic [KIDX_W-1:0]  kp_ff;
   logic [BYTE_W-1:0]  bc_ff;
   logic [BYTE_W-1:0]  mix_ff, mix_in;
   logic [BYTE_W-1:0]  ks_ff [MAX_KEY_BYTES];
   logic [BYTE_W-1:0]  ksn_ff, kn_ff, sa_ff, data_ff, out_ff;

   // s-box memory with per-entry valid bits, unwritten entries read as identity
   logic [BYTE_W-1:0]     sbox_mem [SBOX_DEPTH];
   logic [SBOX_DEPTH-1:0] sb_vld_ff;
   logic [BYTE_W-1:0]     rd_data_ff;
   logic [SBOX_AW-1:0]    rd_addr_ff;
   logic                  rd_valid_ff;
   logic [BYTE_W-1:0]     rdata;
   logic [SBOX_AW-1:0]    sb_addr;
   logic                  sb_we;
   logic [BYTE_W-1:0]     sb_wdata;

   // key-state access
   logic [KIDX_W-1:0] ks_raddr, ks_waddr;
   logic              ks_we;
   logic [BYTE_W-1:0] ks_rd, ks_wdata;

   logic [BYTE_W-1:0] key_bytes   [KEY_REG_BYTES];
   logic [BYTE_W-1:0] nonce_bytes [NONCE_REG_BYTES];
   logic [BYTE_W-1:0] key_b, nonce_b;
   logic [KIDX_W-1:0] pos_nxt, kp_nxt;
   logic [KLEN_W-1:0] klen_sat;
   logic [NLEN_W-1:0] nlen_sat;

   // index that steps through 0 .. klen-1 and wraps
   function automatic logic [KIDX_W-1:0] wrap_inc(input logic [KIDX_W-1:0] idx,
                                                  input logic [KLEN_W-1:0] len);
      logic [KLEN_W-1:0] inc;
      inc = KLEN_W'(idx) + KLEN_W'(1);
      return (inc == len) ? '0 : inc[KIDX_W-1:0];
   endfunction

   // byte views of the key and nonce registers
   for (genvar g = 0; g < KEY_REG_BYTES / 4; g++) begin : g_key
      assign key_bytes[g]                         = key_low_ff[g*BYTE_W +: BYTE_W];
      assign key_bytes[g + KEY_REG_BYTES / 4]     = key_second_ff[g*BYTE_W +: BYTE_W];
      assign key_bytes[g + KEY_REG_BYTES / 2]     = key_third_ff[g*BYTE_W +: BYTE_W];
      assign key_bytes[g + 3 * KEY_REG_BYTES / 4] = key_high_ff[g*BYTE_W +: BYTE_W];
   end
   for (genvar g = 0; g < NONCE_REG_BYTES / 2; g++) begin : g_nonce
      assign nonce_bytes[g]                       = nonce_low_ff[g*BYTE_W +: BYTE_W];
      assign nonce_bytes[g + NONCE_REG_BYTES / 2] = nonce_high_ff[g*BYTE_W +: BYTE_W];
   end

   assign key_b   = key_bytes[KEY_SEL_W'(pos_ff)];
   assign nonce_b = nonce_bytes[cnt_ff[NONCE_SEL_W-1:0]];
   assign pos_nxt = wrap_inc(pos_ff, klen_ff);
   assign kp_nxt  = wrap_inc(kp_ff, klen_ff);
   assign ks_rd   = ks_ff[ks_raddr];
   assign rdata   = rd_valid_ff ? rd_data_ff : rd_addr_ff;

   // length limits taken at the start of a schedule
   always_comb begin
      if (key_len_ff == '0) begin
         klen_sat = KLEN_W'(1);
      end else if (key_len_ff > KEYLEN_W'(MAX_KEY_BYTES)) begin
         klen_sat = KLEN_W'(MAX_KEY_BYTES);
      end else begin
         klen_sat = KLEN_W'(key_len_ff);
      end
      if (nonce_len_ff > NONCELEN_W'(MAX_NONCE_BYTES)) begin
         nlen_sat = NLEN_W'(MAX_NONCE_BYTES);
      end else begin
         nlen_sat = NLEN_W'(nonce_len_ff);
      end
   end

   // loop end detection
   always_comb begin
      stat.nonce_empty = (nlen_ff == '0);
      case (cmd.op)
         OP_KEY:   stat.loop_last = (cnt_ff == CNT_W'(klen_ff) - CNT_W'(1));
         OP_MIX:   stat.loop_last = (cnt_ff == CNT_W'(MIX_ROUNDS - 1));
         OP_NONCE: stat.loop_last = (cnt_ff == CNT_W'(nlen_ff) - CNT_W'(1));
         default:  stat.loop_last = 1'b0;
      endcase
   end

   // adders and memory address selection
   always_comb begin
      ks_raddr = pos_ff;
      ks_waddr = pos_ff;
      ks_we    = 1'b0;
      ks_wdata = key_b;
      mix_in   = mix_ff;
      sb_addr  = '0;
      sb_we    = 1'b0;
      sb_wdata = rdata;
      case (cmd.op)
         OP_CLEAR: begin
            mix_in = '0;
         end
         OP_KEY: begin
            ks_we  = 1'b1;
            mix_in = mix_ff + key_b;
         end
         OP_MIX: begin
            ks_we    = 1'b1;
            ks_wdata = ks_rd + mix_ff;
            mix_in   = mix_ff + ks_wdata + cnt_ff[BYTE_W-1:0];
         end
         OP_NONCE: begin
            ks_we    = 1'b1;
            ks_wdata = ks_rd + nonce_b;
            mix_in   = mix_ff + ks_wdata;
         end
         OP_SW_A: begin
            sb_addr = '0;
         end
         OP_SW_B: begin
            sb_addr = mix_ff;
         end
         OP_SW_C: begin
            sb_addr  = '0;
            sb_we    = 1'b1;
            sb_wdata = rdata;
         end
         OP_SW_D: begin
            sb_addr  = mix_ff;
            sb_we    = 1'b1;
            sb_wdata = sa_ff;
         end
         OP_DT_A: begin
            ks_raddr = kp_nxt;
            sb_addr  = bc_ff;
         end
         OP_DT_B: begin
            ks_raddr = kp_ff;
            ks_waddr = kp_ff;
            ks_we    = 1'b1;
            ks_wdata = ks_rd + ksn_ff + mix_ff;
            mix_in   = mix_ff + ks_wdata + bc_ff;
            sb_addr  = mix_in;
         end
         OP_DT_C: begin
            sb_addr  = bc_ff;
            sb_we    = 1'b1;
            sb_wdata = rdata;
         end
         OP_DT_D: begin
            sb_addr  = mix_ff;
            sb_we    = 1'b1;
            sb_wdata = sa_ff;
         end
         default: begin
            mix_in = mix_ff;
         end
      endcase
   end

   // config registers, counters and s-box valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_second_ff <= '0;
         key_third_ff  <= '0;
         key_high_ff   <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
         key_len_ff    <= KEYLEN_RESET;
         nonce_len_ff  <= NONCELEN_RESET;
         klen_ff       <= KLEN_W'(MAX_KEY_BYTES);
         nlen_ff       <= '0;
         cnt_ff        <= '0;
         pos_ff        <= '0;
         kp_ff         <= '0;
         bc_ff         <= '0;
         mix_ff        <= '0;
         sb_vld_ff     <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_idx_type'(csr_index))
               CSR_KEY_LOW:      key_low_ff    <= csr_data;
               CSR_KEY_SECOND:   key_second_ff <= csr_data;
               CSR_KEY_THIRD:    key_third_ff  <= csr_data;
               CSR_KEY_HIGH:     key_high_ff   <= csr_data;
               CSR_NONCE_LOW:    nonce_low_ff  <= csr_data;
               CSR_NONCE_HIGH:   nonce_high_ff <= csr_data;
               CSR_KEY_LENGTH:   key_len_ff    <= csr_data[KEYLEN_W-1:0];
               CSR_NONCE_LENGTH: nonce_len_ff  <= csr_data[NONCELEN_W-1:0];
               default:          key_len_ff    <= key_len_ff;
            endcase
         end
         mix_ff <= mix_in;
         if (cmd.op == OP_CLEAR) begin
            sb_vld_ff <= '0;
         end else if (sb_we) begin
            sb_vld_ff[sb_addr] <= 1'b1;
         end
         case (cmd.op)
            OP_CLEAR: begin
               klen_ff <= klen_sat;
               nlen_ff <= nlen_sat;
               cnt_ff  <= '0;
               pos_ff  <= '0;
               kp_ff   <= '0;
               bc_ff   <= '0;
            end
            OP_KEY, OP_MIX, OP_NONCE: begin
               if (stat.loop_last) begin
                  cnt_ff <= '0;
                  pos_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
                  pos_ff <= pos_nxt;
               end
            end
            OP_DT_D: begin
               bc_ff <= bc_ff + BYTE_W'(1);
               kp_ff <= kp_nxt;
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

   // key-state array and word registers
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLEAR) begin
         for (int n = 0; n < MAX_KEY_BYTES; n++) begin
            ks_ff[n] <= '0;
         end
      end else if (ks_we) begin
         ks_ff[ks_waddr] <= ks_wdata;
      end
      if (cmd.capture) data_ff <= req_data_byte;
      if (cmd.op == OP_DT_A) ksn_ff <= ks_rd;
      if (cmd.op == OP_DT_B) kn_ff <= ks_wdata;
      if (cmd.op == OP_SW_B || cmd.op == OP_DT_B) sa_ff <= rdata;
      if (cmd.op == OP_DT_D) out_ff <= data_ff ^ sa_ff ^ kn_ff;
   end

   // s-box memory, one port, registered read
   always_ff @(posedge clock) begin
      if (sb_we) sbox_mem[sb_addr] <= sb_wdata;
      rd_data_ff  <= sbox_mem[sb_addr];
      rd_addr_ff  <= sb_addr;
      rd_valid_ff <= sb_vld_ff[sb_addr];
   end

   assign rsp_out_byte = out_ff;

endmodule

`default_nettype wire

FILE: hdl/ssc_checker.sv
// ssc_checker: port-level assertions for sbox_stream_cipher, bound to the top
// depends on ssc_pkg and the top level's channel ports
`default_nettype none

module ssc_checker
   import ssc_pkg::*;
   (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] rsp_out_byte
   );

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte))
      else $error("result word changed while stalled");

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted back to back");

endmodule

bind sbox_stream_cipher ssc_checker u_ssc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte)
);

`default_nettype wire

FILE: bench/tb_sbox_stream_cipher.sv
// tb_sbox_stream_cipher: self-checking bench for the sbox stream cipher, with its own
// byte-by-byte keystream predictor, random handshake gaps and register sweeps
// depends on ssc_pkg, the ssc channel interfaces and the sbox_stream_cipher rtl
`default_nettype none

module tb_sbox_stream_cipher;
   import ssc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssc_req_if req_bus ();
   ssc_rsp_if rsp_bus ();
   ssc_csr_if csr_bus ();

   sbox_stream_cipher DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #6 clock = ~clock;

   // predictor copy of the registers
   logic [WORD_W-1:0]     key_word_q [4];
   logic [WORD_W-1:0]     nonce_word_q [2];
   logic [KEYLEN_W-1:0]   key_len_q;
   logic [NONCELEN_W-1:0] nonce_len_q;

   // predictor copy of the cipher state
   logic [BYTE_W-1:0] perm [SBOX_DEPTH];
   logic [BYTE_W-1:0] kstate [KEY_REG_BYTES];
   logic [BYTE_W-1:0] mix_j;
   logic [BYTE_W-1:0] byte_cnt;
   int                kpos;
   int                act_len;
   bit                keyed;

   // output bytes still owed by the block, oldest first
   logic [BYTE_W-1:0] expected_bytes [$];

   int send_gap_pct    = 0;
   int recv_gap_pct    = 0;
   int rsp_hold_cycles = 0;
   int error_count     = 0;

   // ---------------------------------------------------------------- predictor

   function automatic void reset_predictor();
      int c;
      for (c = 0; c < 4; c++) key_word_q[c] = '0;
      for (c = 0; c < 2; c++) nonce_word_q[c] = '0;
      key_len_q   = KEYLEN_RESET;
      nonce_len_q = NONCELEN_RESET;
      for (c = 0; c < SBOX_DEPTH; c++) perm[c] = BYTE_W'(c);
      for (c = 0; c < KEY_REG_BYTES; c++) kstate[c] = '0;
      mix_j    = '0;
      byte_cnt = '0;
      kpos     = 0;
      act_len  = DEF_MAX_KEY_BYTES;
      keyed    = 1'b0;
   endfunction

   function automatic void swap_perm(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t       = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
   endfunction

   // one mixing loop, closed by the swap of entry zero with entry j
   function automatic void churn_key_state();
      int c, p;
      for (c = 0; c < MIX_ROUNDS; c++) begin
         p         = c % act_len;
         kstate[p] = kstate[p] + mix_j;
         mix_j     = mix_j + kstate[p] + BYTE_W'(c);
      end
      swap_perm(BYTE_W'(MIX_ROUNDS), mix_j);
   endfunction

   function automatic void load_key_schedule();
      int klen, nlen, c, p;
      klen = key_len_q;
      if (klen == 0) klen = 1;
      if (klen > DEF_MAX_KEY_BYTES) klen = DEF_MAX_KEY_BYTES;
      nlen = nonce_len_q;
      if (nlen > DEF_MAX_NONCE_BYTES) nlen = DEF_MAX_NONCE_BYTES;
      act_len = klen;
      for (c = 0; c < SBOX_DEPTH; c++) perm[c] = BYTE_W'(c);
      for (c = 0; c < KEY_REG_BYTES; c++) kstate[c] = '0;
      mix_j = '0;
      // fold in the key bytes
      for (c = 0; c < klen; c++) begin
         kstate[c] = kstate[c] + key_word_q[c >> 3][8*(c % 8) +: 8];
         mix_j     = mix_j + kstate[c];
      end
      churn_key_state();
      // fold in the nonce bytes, wrapping over the key length
      for (c = 0; c < nlen; c++) begin
         p         = c % klen;
         kstate[p] = kstate[p] + nonce_word_q[c >> 3][8*(c % 8) +: 8];
         mix_j     = mix_j + kstate[p];
      end
      churn_key_state();
      byte_cnt = '0;
      kpos     = 0;
      keyed    = 1'b1;
   endfunction

   function automatic logic [BYTE_W-1:0] encrypt_byte(logic [BYTE_W-1:0] data,
                                                      logic restart);
      int i, nxt;
      if (restart || !keyed) load_key_schedule();
      i         = kpos % act_len;
      nxt       = (i + 1) % act_len;
      kstate[i] = kstate[i] + kstate[nxt] + mix_j;
      mix_j     = mix_j + kstate[i] + byte_cnt;
      swap_perm(byte_cnt, mix_j);
      encrypt_byte = data ^ perm[mix_j] ^ kstate[i];
      byte_cnt  = byte_cnt + 1'b1;
      kpos      = nxt;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   // offer one word, leave valid high after the accepting edge
   task automatic send_byte(logic [BYTE_W-1:0] data, logic restart);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.restart   <= restart;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_bytes.push_back(encrypt_byte(data, restart));
   endtask

   // stop offering and wait for every owed byte
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_KEY_LOW:      key_word_q[0]   = value;
         CSR_KEY_SECOND:   key_word_q[1]   = value;
         CSR_KEY_THIRD:    key_word_q[2]   = value;
         CSR_KEY_HIGH:     key_word_q[3]   = value;
         CSR_NONCE_LOW:    nonce_word_q[0] = value;
         CSR_NONCE_HIGH:   nonce_word_q[1] = value;
         CSR_KEY_LENGTH:   key_len_q       = value[KEYLEN_W-1:0];
         CSR_NONCE_LENGTH: nonce_len_q     = value[NONCELEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // random register value, lengths mostly in range with clamped cases mixed in
   function automatic logic [WORD_W-1:0] pick_reg_value(csr_idx_type idx);
      logic [WORD_W-1:0] v;
      v = {$urandom(), $urandom()};
      case (idx)
         CSR_KEY_LENGTH:
            case ($urandom_range(9))
               0:       v[KEYLEN_W-1:0] = '0;
               1:       v[KEYLEN_W-1:0] = KEYLEN_W'($urandom_range(33, 63));
               default: v[KEYLEN_W-1:0] = KEYLEN_W'($urandom_range(1, KEY_REG_BYTES));
            endcase
         CSR_NONCE_LENGTH:
            if ($urandom_range(7) == 0)
               v[NONCELEN_W-1:0] = NONCELEN_W'($urandom_range(17, 31));
            else
               v[NONCELEN_W-1:0] = NONCELEN_W'($urandom_range(0, NONCE_REG_BYTES));
         default:
            case ($urandom_range(15))
               0:       v = '0;
               1:       v = '1;
               default: ;
            endcase
      endcase
      return v;
   endfunction

   task automatic randomize_regs();
      csr_idx_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         if ($urandom_range(1)) write_reg(idx, pick_reg_value(idx));
         idx = idx.next();
      end
   endtask

   // result receiver: random gaps, or a counted hold-off when asked
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [BYTE_W-1:0] want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_bytes.size() == 0) begin
            flag_error($sformatf("unexpected word out_byte=%h", rsp_bus.out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.out_byte !== want)
               flag_error($sformatf("out_byte mismatch: expected %h, got %h",
                                    want, rsp_bus.out_byte));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // first words after reset key from the default registers, with or without restart
   task automatic test_first_word_after_reset();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
      wait_drained();
   endtask

   // all-ones key and nonce at full length, then an all-zero one-byte key, no nonce
   task automatic test_register_extremes();
      write_reg(CSR_KEY_LOW,      '1);
      write_reg(CSR_KEY_SECOND,   '1);
      write_reg(CSR_KEY_THIRD,    '1);
      write_reg(CSR_KEY_HIGH,     '1);
      write_reg(CSR_NONCE_LOW,    '1);
      write_reg(CSR_NONCE_HIGH,   '1);
      write_reg(CSR_KEY_LENGTH,   WORD_W'(KEY_REG_BYTES));
      write_reg(CSR_NONCE_LENGTH, WORD_W'(NONCE_REG_BYTES));
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      wait_drained();
      write_reg(CSR_KEY_LOW,      '0);
      write_reg(CSR_KEY_LENGTH,   64'd1);
      write_reg(CSR_NONCE_LENGTH, 64'd0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      wait_drained();
   endtask

   // zero key length, lengths above the maximum, junk in the upper data bits
   task automatic test_length_clamping();
      write_reg(CSR_KEY_LOW, {$urandom(), $urandom()});
      write_reg(CSR_KEY_LENGTH, 64'd0);
      send_byte(8'($urandom), 1'b1);
      wait_drained();
      write_reg(CSR_KEY_LENGTH,   64'd63);
      write_reg(CSR_NONCE_LENGTH, 64'd31);
      send_byte(8'($urandom), 1'b1);
      wait_drained();
      write_reg(CSR_KEY_LENGTH,   64'hDEAD_BEEF_0000_0061);
      write_reg(CSR_NONCE_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
      send_byte(8'($urandom), 1'b1);
      wait_drained();
   endtask

   // key writes inside a message only take hold at the next restart
   task automatic test_write_mid_message();
      send_byte(8'($urandom), 1'b1);
      wait_drained();
      write_reg(CSR_KEY_LOW,    {$urandom(), $urandom()});
      write_reg(CSR_NONCE_HIGH, {$urandom(), $urandom()});
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
      wait_drained();
   endtask

   // receiver holds off while words keep coming, so the input backs up
   task automatic test_receiver_holdoff();
      send_byte(8'($urandom), 1'b1);
      wait_drained();
      rsp_hold_cycles = 200;
      repeat (8) send_byte(8'($urandom), 1'b0);
      wait_drained();
   endtask

   // messages of random length, mostly restarted, with register changes between
   task automatic test_random_traffic(int send_pct, int recv_pct, int n_words,
                                      bit long_first);
      int sent, msg_len, b;
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(3) == 0) begin
            wait_drained();
            randomize_regs();
         end
         if (long_first) begin
            // long enough to wrap the byte counter
            msg_len    = 270;
            long_first = 1'b0;
         end else if ($urandom_range(9) == 0) begin
            msg_len = $urandom_range(100, 300);
         end else begin
            msg_len = $urandom_range(1, 40);
         end
         // keep the total at the requested word count
         if (msg_len > n_words - sent) msg_len = n_words - sent;
         send_byte(8'($urandom), $urandom_range(7) != 0);
         for (b = 1; b < msg_len; b++)
            send_byte(8'($urandom), $urandom_range(199) == 0);
         sent += msg_len;
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.restart   = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_KEY_LOW;
      csr_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      reset_predictor();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_word_after_reset();
      test_register_extremes();
      test_length_clamping();
      test_write_mid_message();
      test_receiver_holdoff();
      test_random_traffic(37, 79, 520, 1'b1);
      test_random_traffic(79, 37, 520, 1'b0);
      test_random_traffic(0, 0, 510, 1'b0);

      // allow time for anything stray
      repeat (16) @(posedge clock);
      if (expected_bytes.size() != 0)
         flag_error($sformatf("%0d words never came out", expected_bytes.size()));
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #12_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
hdl/ssc_pkg.sv
hdl/ssc_channels.sv
hdl/ssc_ctrl.sv
hdl/ssc_dpath.sv
hdl/sbox_stream_cipher.sv
hdl/ssc_checker.sv
bench/tb_sbox_stream_cipher.sv
